>>> rtl/blt_pkg.sv
// shared constants, types and helper functions for the bernsen threshold block
package blt_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_HW     = 8;
  localparam int PADW_MAX   = MAX_WIDTH + 2 * MAX_HW;
  localparam int LS_LINES   = 2 * MAX_HW - 1;
  localparam int COL_DEPTH  = 2 * MAX_HW;

  localparam int W_W    = 11;
  localparam int H_W    = 13;
  localparam int D_W    = 4;
  localparam int N_W    = 5;
  localparam int COL_W  = $clog2(PADW_MAX);
  localparam int SLOT_W = $clog2(LS_LINES);
  localparam int TAP_W  = $clog2(COL_DEPTH);
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 13;

  localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_HALF_WIN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_COL  = 4'b0100,
    ST_WIN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic col;
    logic win;
  } cmd_t;

  typedef struct packed {
    logic out_full;
    logic emit;
  } sts_t;

  typedef logic [COL_DEPTH-1:0][7:0] vec16_t;

  function automatic logic [7:0] tree_max(input vec16_t v);
    logic [7:0][7:0] l1;
    logic [3:0][7:0] l2;
    logic [1:0][7:0] l3;
    for (int i = 0; i < 8; i++) l1[i] = (v[2*i] > v[2*i+1]) ? v[2*i] : v[2*i+1];
    for (int i = 0; i < 4; i++) l2[i] = (l1[2*i] > l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
    for (int i = 0; i < 2; i++) l3[i] = (l2[2*i] > l2[2*i+1]) ? l2[2*i] : l2[2*i+1];
    return (l3[0] > l3[1]) ? l3[0] : l3[1];
  endfunction

  function automatic logic [7:0] tree_min(input vec16_t v);
    logic [7:0][7:0] l1;
    logic [3:0][7:0] l2;
    logic [1:0][7:0] l3;
    for (int i = 0; i < 8; i++) l1[i] = (v[2*i] < v[2*i+1]) ? v[2*i] : v[2*i+1];
    for (int i = 0; i < 4; i++) l2[i] = (l1[2*i] < l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
    for (int i = 0; i < 2; i++) l3[i] = (l2[2*i] < l2[2*i+1]) ? l2[2*i] : l2[2*i+1];
    return (l3[0] < l3[1]) ? l3[0] : l3[1];
  endfunction

endpackage

>>> rtl/blt_ctrl.sv
// controller state machine sequencing one pixel through the datapath
module blt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_ready,
  input  blt_pkg::sts_t sts,
  output logic          in_ready,
  output blt_pkg::cmd_t cmd
);
  import blt_pkg::*;

  state_t state, state_next;
  logic   win_free;

  assign win_free = !(sts.out_full && !out_ready);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_COL;
      end
      ST_COL: begin
        cmd.col    = 1'b1;
        state_next = ST_WIN;
      end
      ST_WIN: begin
        // hold while a result still waits downstream
        if (win_free) begin
          cmd.win    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

>>> rtl/blt_dp.sv
// datapath: position counters, banked line stores, column and window extremes
module blt_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  blt_pkg::cmd_t             cmd,
  output blt_pkg::sts_t             sts,
  input  logic [7:0]                pixel,
  input  logic                      frame_start,
  input  logic                      cfg_we,
  input  logic [blt_pkg::IDX_W-1:0] cfg_index,
  input  logic [blt_pkg::CFG_W-1:0] cfg_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      out_bit,
  output logic                      out_last
);
  import blt_pkg::*;

  // configuration, stored already clamped
  logic [W_W-1:0] width_c;
  logic [H_W-1:0] height_c;
  logic [D_W-1:0] hw_c;

  logic [N_W-1:0]    n_win;
  logic [SLOT_W-1:0] lines;
  logic [COL_W-1:0]  pw;
  logic [H_W-1:0]    ph;

  assign n_win = {hw_c, 1'b0};
  assign lines = SLOT_W'(n_win - N_W'(1));
  assign pw    = COL_W'(width_c) + COL_W'(n_win);
  assign ph    = height_c + H_W'(n_win);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_c  <= W_W'(640);
      height_c <= H_W'(480);
      hw_c     <= D_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH: begin
          if (cfg_data[W_W-1:0] == '0) width_c <= W_W'(1);
          else if (cfg_data[W_W-1:0] > W_W'(MAX_WIDTH)) width_c <= W_W'(MAX_WIDTH);
          else width_c <= cfg_data[W_W-1:0];
        end
        REG_HEIGHT: begin
          if (cfg_data[H_W-1:0] == '0) height_c <= H_W'(1);
          else if (cfg_data[H_W-1:0] > H_W'(MAX_HEIGHT)) height_c <= H_W'(MAX_HEIGHT);
          else height_c <= cfg_data[H_W-1:0];
        end
        REG_HALF_WIN: begin
          if (cfg_data[D_W-1:0] == '0) hw_c <= D_W'(1);
          else if (cfg_data[D_W-1:0] > D_W'(MAX_HW)) hw_c <= D_W'(MAX_HW);
          else hw_c <= cfg_data[D_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // position of the next padded pixel and its line store slot
  logic [COL_W-1:0]  col_idx;
  logic [H_W-1:0]    row_idx;
  logic [SLOT_W-1:0] slot_idx;

  // current pixel
  logic [COL_W-1:0]  cur_c;
  logic [H_W-1:0]    cur_r;
  logic [SLOT_W-1:0] cur_s;
  logic [7:0]        cur_pix;

  logic [COL_W-1:0]  c0, c1;
  logic [H_W:0]      r0, r1;
  logic [SLOT_W-1:0] s0, s1;
  logic [SLOT_W:0]   s_inc;

  always_comb begin
    c0 = frame_start ? '0 : col_idx;
    r0 = frame_start ? '0 : {1'b0, row_idx};
    s0 = frame_start ? '0 : slot_idx;
    c1 = c0;
    r1 = r0;
    s1 = s0;
    s_inc = {1'b0, s0} + (SLOT_W+1)'(1);
    if (c0 >= pw) begin
      c1 = '0;
      r1 = r0 + (H_W+1)'(1);
      s1 = (s_inc >= {1'b0, lines}) ? '0 : s_inc[SLOT_W-1:0];
    end
    if (r1 >= {1'b0, ph}) begin
      r1 = '0;
      s1 = '0;
    end
  end

  // advance after the current pixel
  logic [COL_W:0]    c_nx;
  logic [H_W:0]      r_nx;
  logic [SLOT_W:0]   s_nx;
  logic [COL_W-1:0]  col_idx_next;
  logic [H_W-1:0]    row_idx_next;
  logic [SLOT_W-1:0] slot_idx_next;

  always_comb begin
    c_nx          = {1'b0, cur_c} + (COL_W+1)'(1);
    r_nx          = {1'b0, cur_r} + (H_W+1)'(1);
    s_nx          = {1'b0, cur_s} + (SLOT_W+1)'(1);
    col_idx_next  = c_nx[COL_W-1:0];
    row_idx_next  = cur_r;
    slot_idx_next = cur_s;
    if (c_nx >= {1'b0, pw}) begin
      col_idx_next  = '0;
      row_idx_next  = r_nx[H_W-1:0];
      slot_idx_next = (s_nx >= {1'b0, lines}) ? '0 : s_nx[SLOT_W-1:0];
      if (r_nx >= {1'b0, ph}) begin
        row_idx_next  = '0;
        slot_idx_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx  <= '0;
      row_idx  <= '0;
      slot_idx <= '0;
    end else if (cmd.col) begin
      col_idx  <= col_idx_next;
      row_idx  <= row_idx_next;
      slot_idx <= slot_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_c   <= c1;
      cur_r   <= r1[H_W-1:0];
      cur_s   <= s1;
      cur_pix <= pixel;
    end
  end

  // one line store bank per previous row, all read at the same column
  logic [LS_LINES-1:0][7:0] rd_data;

  for (genvar b = 0; b < LS_LINES; b++) begin : g_bank
    logic [7:0] mem [PADW_MAX];
    always_ff @(posedge clk) begin
      if (cmd.read) rd_data[b] <= mem[cur_c];
      if (cmd.col && cur_s == SLOT_W'(b)) mem[cur_c] <= cur_pix;
    end
  end

  // column extremes over the current pixel and the stored rows above it
  vec16_t            col_vals;
  logic [7:0]        col_max, col_min, mid_val;
  logic [SLOT_W-1:0] mid_bank;
  logic [SLOT_W:0]   hw_m1;

  always_comb begin
    logic [SLOT_W:0] kb;
    col_vals[0] = cur_pix;
    for (int b = 0; b < LS_LINES; b++) begin
      if ({1'b0, cur_s} >= (SLOT_W+1)'(b))
        kb = {1'b0, cur_s} - (SLOT_W+1)'(b);
      else
        kb = {1'b0, cur_s} + {1'b0, lines} - (SLOT_W+1)'(b);
      if (kb == '0) kb = {1'b0, lines};
      if ((SLOT_W'(b) < lines) && (H_W'(kb) <= cur_r))
        col_vals[b+1] = rd_data[b];
      else
        col_vals[b+1] = cur_pix;
    end
  end

  assign col_max = tree_max(col_vals);
  assign col_min = tree_min(col_vals);

  // the centre pixel lies d-1 rows above the current one
  assign hw_m1    = (SLOT_W+1)'(hw_c) - (SLOT_W+1)'(1);
  assign mid_bank = ({1'b0, cur_s} >= hw_m1) ? SLOT_W'({1'b0, cur_s} - hw_m1)
                                             : SLOT_W'({1'b0, cur_s} + {1'b0, lines} - hw_m1);
  assign mid_val  = (hw_c == D_W'(1)) ? cur_pix : rd_data[mid_bank];

  // last 2d columns of extremes and centre candidates
  vec16_t max_sr, min_sr, mid_sr;
  logic   emit, last;

  always_ff @(posedge clk) begin
    if (cmd.col) begin
      for (int j = COL_DEPTH - 1; j > 0; j--) begin
        max_sr[j] <= max_sr[j-1];
        min_sr[j] <= min_sr[j-1];
        mid_sr[j] <= mid_sr[j-1];
      end
      max_sr[0] <= col_max;
      min_sr[0] <= col_min;
      mid_sr[0] <= mid_val;
      emit <= (cur_r >= H_W'(lines)) && (COL_W'(cur_c) >= COL_W'(lines))
              && (cur_r < ph - H_W'(1)) && (cur_c < pw - COL_W'(1));
      last <= (cur_r == ph - H_W'(2)) && (cur_c == pw - COL_W'(2));
    end
  end

  // window extremes and threshold test
  vec16_t           win_max_in, win_min_in;
  logic [7:0]       win_max, win_min, centre;
  logic [8:0]       sum_mm;
  logic             res_bit;
  logic [TAP_W-1:0] centre_tap;

  always_comb begin
    for (int j = 0; j < COL_DEPTH; j++) begin
      win_max_in[j] = (N_W'(j) < n_win) ? max_sr[j] : 8'd0;
      win_min_in[j] = (N_W'(j) < n_win) ? min_sr[j] : 8'd255;
    end
  end

  assign win_max    = tree_max(win_max_in);
  assign win_min    = tree_min(win_min_in);
  assign centre_tap = TAP_W'(hw_c - D_W'(1));
  assign centre     = mid_sr[centre_tap];
  assign sum_mm     = {1'b0, win_max} + {1'b0, win_min};
  assign res_bit    = ({centre, 1'b0} >= sum_mm);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.win && emit) out_valid <= 1'b1;
      else if (out_ready)  out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win && emit) begin
      out_bit  <= res_bit;
      out_last <= last;
    end
  end

  assign sts.out_full = out_valid;
  assign sts.emit     = emit;

endmodule

>>> rtl/bernsen_local_threshold.sv
// top level: bernsen local threshold over a padded grey pixel stream
// results: where a pixel gives one, its result is registered when its window step completes
// input: a new pixel is taken only after the current one has passed the read, column
//   and window steps of the controller; the window step waits while a result is pending
// reset: rst (synchronous, active high) clears counters, handshakes and the
//   configuration to 640 x 480 with half window 1; line stores are not cleared
module bernsen_local_threshold (
  input  logic                      clk,
  input  logic                      rst,
  // pixel input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] pixel
  input  logic                      s_axis_tuser,  // [0] frame_start
  // binary output
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [0] binary_pixel, [7:1] zero
  output logic                      m_axis_tlast,  // frame_end
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [blt_pkg::IDX_W-1:0] cfg_index,
  input  logic [blt_pkg::CFG_W-1:0] cfg_data
);
  import blt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_bit;

  // registers may be written at any time; the user keeps to idle periods
  assign cfg_ready = 1'b1;

  blt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .in_ready  (s_axis_tready),
    .cmd       (cmd)
  );

  blt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .pixel       (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_bit     (out_bit),
    .out_last    (m_axis_tlast)
  );

  // white is 1, padded to a byte
  assign m_axis_tdata = {7'd0, out_bit};

  // one pixel in flight: no new transfer right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a pixel is in flight");

  // a new result only appears when the window step completes
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.win && sts.emit))
    else $error("result appeared outside the window step");

  // window step never overwrites a result still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.win |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pending result overwritten");

endmodule
